// File: src/pfmt_pkg.sv
// ---------------------------------------------------------------------------
// pfmt_pkg: shared types and constants for the printf number formatter
// Command and status structs between controller and datapath, character
// codes, and the nibble-to-ASCII helper.
// ---------------------------------------------------------------------------
package pfmt_pkg;

	localparam int BYTE_W     = 8;
	localparam int ARG_W      = 64;
	localparam int COUNT_W    = 31;
	localparam int BIN_W      = 32;
	localparam int NIB_W      = 4;
	localparam int DEC_DIGITS = 10;
	localparam int BCD_W      = DEC_DIGITS * NIB_W;
	localparam int DIG_BUF_W  = 64;
	localparam int DIG_CNT_W  = 5;
	localparam int CONV_CNT_W = 5;
	localparam int S_TDATA_W  = BYTE_W + ARG_W;          // 72, whole bytes
	localparam int M_TDATA_W  = 40;                      // 8 + 31, padded

	localparam logic [DIG_CNT_W-1:0] HEX32_DIGITS = 5'd8;
	localparam logic [DIG_CNT_W-1:0] PTR_DIGITS   = 5'd16;
	localparam logic [DIG_CNT_W-1:0] DEC_LOAD_DIG = 5'd10;

	localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_LC_A    = 8'h61;
	localparam logic [BYTE_W-1:0] CH_UC_A    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_LC_C    = 8'h63;
	localparam logic [BYTE_W-1:0] CH_LC_D    = 8'h64;
	localparam logic [BYTE_W-1:0] CH_LC_I    = 8'h69;
	localparam logic [BYTE_W-1:0] CH_LC_U    = 8'h75;
	localparam logic [BYTE_W-1:0] CH_LC_X    = 8'h78;
	localparam logic [BYTE_W-1:0] CH_UC_X    = 8'h58;
	localparam logic [BYTE_W-1:0] CH_LC_P    = 8'h70;

	typedef enum logic [1:0] {
		MODE_CHAR,
		MODE_DEC,
		MODE_HEX32,
		MODE_PTR
	} load_mode_t;

	typedef enum logic [1:0] {
		HELD_BYTE,
		HELD_ARG,
		HELD_PCT
	} held_sel_t;

	typedef enum logic [2:0] {
		EMIT_HELD,
		EMIT_MINUS,
		EMIT_ZERO,
		EMIT_X,
		EMIT_DIGIT
	} emit_sel_t;

	typedef struct packed {
		logic       accept;
		logic       clear_count;
		load_mode_t mode;
		held_sel_t  held;
		logic       negate;
		logic       upper;
		logic       emit;
		emit_sel_t  sel;
		logic       last;
		logic       conv_step;
		logic       skip;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic conv_done;
		logic top_zero;
		logic ndig_one;
	} dp_sts_t;

	function automatic logic [BYTE_W-1:0] hex_char(input logic [NIB_W-1:0] nib,
			input logic upper);
		logic [BYTE_W-1:0] wide;
		wide = {{(BYTE_W-NIB_W){1'b0}}, nib};
		if (nib < 4'd10) begin
			hex_char = CH_ZERO + wide;
		end else if (upper) begin
			hex_char = CH_UC_A + wide - 8'd10;
		end else begin
			hex_char = CH_LC_A + wide - 8'd10;
		end
	endfunction

endpackage

// File: src/pfmt_datapath.sv
// ---------------------------------------------------------------------------
// pfmt_datapath: argument registers, conversion unit and output register
// Holds the accepted argument, runs the binary-to-BCD shift-add-3 loop,
// walks the digit buffer from the top nibble, keeps the saturating count.
// ---------------------------------------------------------------------------
module pfmt_datapath #(
	parameter int POINTER_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfmt_pkg::ctl_cmd_t             cmd,
	output pfmt_pkg::dp_sts_t              sts,
	input  logic [pfmt_pkg::BYTE_W-1:0]    byte_value,
	input  logic [pfmt_pkg::ARG_W-1:0]     arg_value,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pfmt_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast
);

	localparam logic [pfmt_pkg::ARG_W-1:0] PTR_MASK =
		{pfmt_pkg::ARG_W{1'b1}} >> (pfmt_pkg::ARG_W - POINTER_BITS);
	localparam int DEC_PAD = pfmt_pkg::DIG_BUF_W - pfmt_pkg::BCD_W;

	logic [pfmt_pkg::BYTE_W-1:0]     held_q;
	logic                            upper_q;
	logic [pfmt_pkg::BIN_W-1:0]      bin_q;
	logic [pfmt_pkg::BCD_W-1:0]      bcd_q;
	logic [pfmt_pkg::CONV_CNT_W-1:0] cnt_q;
	logic [pfmt_pkg::DIG_BUF_W-1:0]  digits_q;
	logic [pfmt_pkg::DIG_CNT_W-1:0]  ndig_q;
	logic [pfmt_pkg::COUNT_W-1:0]    total_q;
	logic                            out_valid_q;
	logic [pfmt_pkg::BYTE_W-1:0]     out_char_q;
	logic [pfmt_pkg::COUNT_W-1:0]    out_count_q;
	logic                            out_last_q;

	logic [pfmt_pkg::BIN_W-1:0]      word;
	logic [pfmt_pkg::BCD_W-1:0]      bcd_adj;
	logic [pfmt_pkg::BCD_W-1:0]      bcd_next;
	logic [pfmt_pkg::COUNT_W-1:0]    total_inc;
	logic [pfmt_pkg::BYTE_W-1:0]     emit_char;
	logic [pfmt_pkg::NIB_W-1:0]      top_nib;

	assign word    = arg_value[pfmt_pkg::BIN_W-1:0];
	assign top_nib = digits_q[pfmt_pkg::DIG_BUF_W-1 -: pfmt_pkg::NIB_W];

	// add 3 to every BCD digit of five or more, then shift in the next bit
	always_comb begin
		for (int d = 0; d < pfmt_pkg::DEC_DIGITS; d++) begin
			if (bcd_q[d*pfmt_pkg::NIB_W +: pfmt_pkg::NIB_W] >= 4'd5) begin
				bcd_adj[d*pfmt_pkg::NIB_W +: pfmt_pkg::NIB_W] =
					bcd_q[d*pfmt_pkg::NIB_W +: pfmt_pkg::NIB_W] + 4'd3;
			end else begin
				bcd_adj[d*pfmt_pkg::NIB_W +: pfmt_pkg::NIB_W] =
					bcd_q[d*pfmt_pkg::NIB_W +: pfmt_pkg::NIB_W];
			end
		end
		bcd_next = {bcd_adj[pfmt_pkg::BCD_W-2:0], bin_q[pfmt_pkg::BIN_W-1]};
	end

	assign total_inc = (&total_q) ? total_q : total_q + 31'd1;

	always_comb begin
		unique case (cmd.sel)
			pfmt_pkg::EMIT_HELD:  emit_char = held_q;
			pfmt_pkg::EMIT_MINUS: emit_char = pfmt_pkg::CH_MINUS;
			pfmt_pkg::EMIT_ZERO:  emit_char = pfmt_pkg::CH_ZERO;
			pfmt_pkg::EMIT_X:     emit_char = pfmt_pkg::CH_LC_X;
			pfmt_pkg::EMIT_DIGIT: emit_char = pfmt_pkg::hex_char(top_nib, upper_q);
			default:              emit_char = held_q;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ndig_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				cnt_q <= '0;
				if (cmd.clear_count) begin
					total_q <= '0;
				end
				if (cmd.mode == pfmt_pkg::MODE_HEX32) begin
					ndig_q <= pfmt_pkg::HEX32_DIGITS;
				end else if (cmd.mode == pfmt_pkg::MODE_PTR) begin
					ndig_q <= pfmt_pkg::PTR_DIGITS;
				end
			end
			if (cmd.conv_step) begin
				cnt_q <= cnt_q + 5'd1;
				if (sts.conv_done) begin
					ndig_q <= pfmt_pkg::DEC_LOAD_DIG;
				end
			end
			if (cmd.skip || (cmd.emit && cmd.sel == pfmt_pkg::EMIT_DIGIT)) begin
				ndig_q <= ndig_q - 5'd1;
			end
			if (cmd.emit) begin
				total_q     <= total_inc;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			upper_q <= cmd.upper;
			unique case (cmd.mode)
				pfmt_pkg::MODE_CHAR: begin
					unique case (cmd.held)
						pfmt_pkg::HELD_BYTE: held_q <= byte_value;
						pfmt_pkg::HELD_ARG:  held_q <= arg_value[pfmt_pkg::BYTE_W-1:0];
						pfmt_pkg::HELD_PCT:  held_q <= pfmt_pkg::CH_PERCENT;
						default:             held_q <= byte_value;
					endcase
				end
				pfmt_pkg::MODE_DEC: begin
					bin_q <= cmd.negate ? (32'd0 - word) : word;
					bcd_q <= '0;
				end
				pfmt_pkg::MODE_HEX32: begin
					digits_q <= {word, {(pfmt_pkg::DIG_BUF_W-pfmt_pkg::BIN_W){1'b0}}};
				end
				pfmt_pkg::MODE_PTR: begin
					digits_q <= arg_value & PTR_MASK;
				end
				default: begin
					held_q <= byte_value;
				end
			endcase
		end
		if (cmd.conv_step) begin
			bin_q <= {bin_q[pfmt_pkg::BIN_W-2:0], 1'b0};
			bcd_q <= bcd_next;
			if (sts.conv_done) begin
				digits_q <= {bcd_next, {DEC_PAD{1'b0}}};
			end
		end
		if (cmd.skip || (cmd.emit && cmd.sel == pfmt_pkg::EMIT_DIGIT)) begin
			digits_q <= {digits_q[pfmt_pkg::DIG_BUF_W-pfmt_pkg::NIB_W-1:0],
				{pfmt_pkg::NIB_W{1'b0}}};
		end
		if (cmd.emit) begin
			out_char_q  <= emit_char;
			out_count_q <= total_inc;
			out_last_q  <= cmd.last;
		end
	end

	assign sts.out_free  = !out_valid_q || m_tready;
	assign sts.conv_done = (cnt_q == 5'(pfmt_pkg::BIN_W - 1));
	assign sts.top_zero  = (top_nib == 4'd0);
	assign sts.ndig_one  = (ndig_q == 5'd1);

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_count_q, out_char_q};

endmodule

// File: src/pfmt_ctrl.sv
// ---------------------------------------------------------------------------
// pfmt_ctrl: format byte decoder and sequencing state machine
// Decodes each accepted byte, keeps the pending-percent flag and steps the
// datapath through prefix, conversion, zero skipping and digit output.
// ---------------------------------------------------------------------------
module pfmt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pfmt_pkg::BYTE_W-1:0] byte_value,
	input  logic                        arg_sign,
	input  logic                        format_start,
	output pfmt_pkg::ctl_cmd_t          cmd,
	input  pfmt_pkg::dp_sts_t           sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHAR  = 3'd1;
	localparam logic [2:0] ST_SIGN  = 3'd2;
	localparam logic [2:0] ST_P0    = 3'd3;
	localparam logic [2:0] ST_PX    = 3'd4;
	localparam logic [2:0] ST_CONV  = 3'd5;
	localparam logic [2:0] ST_SKIP  = 3'd6;
	localparam logic [2:0] ST_DIGIT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       pending_q;
	logic       pending_d;
	logic       pend;

	assign s_tready = (state_q == ST_IDLE);
	assign pend     = pending_q && !format_start;

	always_comb begin
		state_d         = state_q;
		pending_d       = pending_q;
		cmd             = '0;
		cmd.mode        = pfmt_pkg::MODE_CHAR;
		cmd.held        = pfmt_pkg::HELD_BYTE;
		cmd.sel         = pfmt_pkg::EMIT_HELD;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept      = 1'b1;
					cmd.clear_count = format_start;
					if (!pend) begin
						if (byte_value == pfmt_pkg::CH_PERCENT) begin
							pending_d = 1'b1;
							state_d   = ST_IDLE;
						end else begin
							pending_d = 1'b0;
							state_d   = ST_CHAR;
						end
					end else begin
						pending_d = 1'b0;
						unique case (byte_value)
							pfmt_pkg::CH_LC_C: begin
								cmd.held = pfmt_pkg::HELD_ARG;
								state_d  = ST_CHAR;
							end
							pfmt_pkg::CH_PERCENT: begin
								cmd.held = pfmt_pkg::HELD_PCT;
								state_d  = ST_CHAR;
							end
							pfmt_pkg::CH_LC_D, pfmt_pkg::CH_LC_I: begin
								cmd.mode   = pfmt_pkg::MODE_DEC;
								cmd.negate = arg_sign;
								state_d    = arg_sign ? ST_SIGN : ST_CONV;
							end
							pfmt_pkg::CH_LC_U: begin
								cmd.mode = pfmt_pkg::MODE_DEC;
								state_d  = ST_CONV;
							end
							pfmt_pkg::CH_LC_X: begin
								cmd.mode = pfmt_pkg::MODE_HEX32;
								state_d  = ST_SKIP;
							end
							pfmt_pkg::CH_UC_X: begin
								cmd.mode  = pfmt_pkg::MODE_HEX32;
								cmd.upper = 1'b1;
								state_d   = ST_SKIP;
							end
							pfmt_pkg::CH_LC_P: begin
								cmd.mode = pfmt_pkg::MODE_PTR;
								state_d  = ST_P0;
							end
							default: begin
								state_d = ST_IDLE;
							end
						endcase
					end
				end
			end
			ST_CHAR: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = pfmt_pkg::EMIT_HELD;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = pfmt_pkg::EMIT_MINUS;
					state_d  = ST_CONV;
				end
			end
			ST_P0: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = pfmt_pkg::EMIT_ZERO;
					state_d  = ST_PX;
				end
			end
			ST_PX: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = pfmt_pkg::EMIT_X;
					state_d  = ST_SKIP;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (sts.top_zero && !sts.ndig_one) begin
					cmd.skip = 1'b1;
				end else begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = pfmt_pkg::EMIT_DIGIT;
					cmd.last = sts.ndig_one;
					if (sts.ndig_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pending_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pending_q <= pending_d;
		end
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("character emitted while output register is full");

	a_pending_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tvalid && s_tready) |=> $stable(pending_q))
		else $error("percent flag changed without a transfer");

	a_conv_to_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && sts.conv_done) |=> (state_q == ST_SKIP))
		else $error("decimal conversion did not hand over to digit output");

	a_last_digit_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == ST_IDLE))
		else $error("controller kept busy after the final character");

endmodule

// File: src/printf_number_formatter.sv
// ---------------------------------------------------------------------------
// printf_number_formatter: byte-serial printf conversion subset
// Echoes format bytes and expands %c %d %i %u %x %X %p %% into ASCII.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel: one format byte per transfer with its argument beside it;
//   s_tuser flags the first byte of a new format, which clears the running
//   count and any pending '%'. Master channel: one ASCII character per
//   transfer; m_tlast marks the final character caused by an input byte, and
//   the saturating count since format start rides in the upper tdata bits.
// Sequencing:
//   One byte is worked at a time; s_tready is high only between items.
//   Ordinary byte, %c, %%: accept, then emit. A lone '%' or unknown
//   conversion: accept only. %x/%X: accept, then leading-zero skip and
//   digit output over 8 digits. %p: accept, '0', 'x', then skip and output
//   over 16 digits. %d/%i/%u: accept, a '-' for a negative %d/%i, 32 BCD
//   shift steps (one per cycle), then skip and output over 10 digits.
// Stall and reset:
//   The output register holds a character until m_tready takes it, and the
//   sequencer waits on it; no character is dropped. The next byte is taken
//   while the last character of the previous one still waits. arst_n clears
//   the state machine, the pending flag, the count and the output valid.
// ---------------------------------------------------------------------------
module printf_number_formatter #(
	parameter int POINTER_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] format_byte, [71:8] argument_value
	input  logic [pfmt_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] format_start
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] out_char, [38:8] chars_so_far, [39] zero
	output logic [pfmt_pkg::M_TDATA_W-1:0] m_tdata,
	// last_of_item
	output logic                           m_tlast
);

	pfmt_pkg::ctl_cmd_t cmd;
	pfmt_pkg::dp_sts_t  sts;

	logic [pfmt_pkg::BYTE_W-1:0] byte_value;
	logic [pfmt_pkg::ARG_W-1:0]  arg_value;

	// split the slave payload into its fields
	assign byte_value = s_tdata[pfmt_pkg::BYTE_W-1:0];
	assign arg_value  = s_tdata[pfmt_pkg::S_TDATA_W-1:pfmt_pkg::BYTE_W];

	// decoder and sequencer: sees the byte, the sign bit and the start flag
	pfmt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.byte_value   (byte_value),
		.arg_sign     (arg_value[pfmt_pkg::BIN_W-1]),
		.format_start (s_tuser),
		.cmd          (cmd),
		.sts          (sts)
	);

	// argument registers, BCD converter, digit buffer and output register
	pfmt_datapath #(
		.POINTER_BITS (POINTER_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.byte_value (byte_value),
		.arg_value  (arg_value),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
